@@ design/bcr_pkg.sv @@
// Shared constants for the two-disc collision response block.
`timescale 1ns / 1ps
package bcr_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Restitution register, Q1.FRAC_BITS, reset to one (fully elastic).
  localparam int                REST_W     = 17;
  localparam logic [REST_W-1:0] REST_RESET = 17'd65536;

  // Configuration port geometry and register index.
  localparam int   APB_ADDR_W      = 3;
  localparam int   APB_DATA_W      = 32;
  localparam logic REG_RESTITUTION = 1'b0;

endpackage

@@ design/ball_collision_response_2d.sv @@
// Top level of the two-disc collision response pipeline.
// Path: stages 1-3, the square root, the dividers, stages 4-10, then the output register.
// Throughput: one pair per cycle unless stalled; sqrt and dividers are fully pipelined.
// A stalled output word holds the whole pipeline in place; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets restitution to one (elastic).
`timescale 1ns / 1ps
module ball_collision_response_2d #(
  parameter int WORD_WIDTH = bcr_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = bcr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bcr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bcr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bcr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [WORD_WIDTH-1:0]    a_pos_x,
  input  logic signed [WORD_WIDTH-1:0]    a_pos_y,
  input  logic signed [WORD_WIDTH-1:0]    b_pos_x,
  input  logic signed [WORD_WIDTH-1:0]    b_pos_y,
  input  logic signed [WORD_WIDTH-1:0]    a_vel_x,
  input  logic signed [WORD_WIDTH-1:0]    a_vel_y,
  input  logic signed [WORD_WIDTH-1:0]    b_vel_x,
  input  logic signed [WORD_WIDTH-1:0]    b_vel_y,
  input  logic        [WORD_WIDTH-2:0]    contact_distance,
  input  logic        [WORD_WIDTH-2:0]    a_mass,
  input  logic        [WORD_WIDTH-2:0]    b_mass,
  input  logic                            either_scored,
  // Output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [WORD_WIDTH-1:0]    new_a_vel_x,
  output logic signed [WORD_WIDTH-1:0]    new_a_vel_y,
  output logic signed [WORD_WIDTH-1:0]    new_b_vel_x,
  output logic signed [WORD_WIDTH-1:0]    new_b_vel_y,
  output logic                            hit
);
  import bcr_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int EW  = F + 2;          // e1, cos/sin (signed), mass ratios
  localparam int KNW = W - 1 + EW;     // e1 * mass
  localparam int PW  = W + EW;         // velocity times cos/sin
  localparam int NW  = PW + 1 - F;     // normal and tangent components
  localparam int KW  = EW + 1 + NW + 1;
  localparam int N2  = NW + 5;         // normal component after the impulse
  localparam int BW  = N2 + EW;        // back-rotation products
  localparam int RW  = BW + 1 - F;     // rotated result before saturation
  localparam int CW  = (REST_W > EW) ? REST_W : EW;

  localparam logic signed [RW-1:0] SAT_HI = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [W-1:0] vax;
    logic signed [W-1:0] vay;
    logic signed [W-1:0] vbx;
    logic signed [W-1:0] vby;
  } vel_t;

  // Everything that rides alongside the square root.
  typedef struct packed {
    logic           cand;
    logic           dxn;
    logic           dyn;
    logic [W-2:0]   adx;
    logic [W-2:0]   ady;
    vel_t           vel;
    logic [KNW-1:0] numa;
    logic [KNW-1:0] numb;
    logic [W-1:0]   msum;
    logic [EW-1:0]  e1;
  } sq_side_t;

  // Everything that rides alongside the cosine divider.
  typedef struct packed {
    logic          msum_zero;
    logic [EW-1:0] e1;
    vel_t          vel;
  } dv_side_t;

  // ---------------------------------------------------------------------------
  // Configuration register. pready is tied high, so no access has wait states.
  // ---------------------------------------------------------------------------
  logic [REST_W-1:0] restitution;
  logic              reg_idx;

  assign reg_idx = paddr[APB_ADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= REST_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_RESTITUTION)) begin
      restitution <= pwdata[REST_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_RESTITUTION) begin
      prdata = APB_DATA_W'(restitution);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. The whole pipe moves when the output register can take
  // a word, so a stall freezes every stage together.
  // ---------------------------------------------------------------------------
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // e1 = one + min(restitution, one), sampled as the pair enters.
  logic [EW-1:0] e1_in;
  always_comb begin
    logic [CW-1:0] rest_w;
    logic [CW-1:0] one_w;
    logic [CW-1:0] e_c;
    rest_w = CW'(restitution);
    one_w  = CW'(1) << F;
    e_c    = (rest_w > one_w) ? one_w : rest_w;
    e1_in  = EW'(e_c) + (EW'(1) << F);
  end

  vel_t vel_in;
  assign vel_in = '{vax: a_vel_x, vay: a_vel_y, vbx: b_vel_x, vby: b_vel_y};

  // ---------------------------------------------------------------------------
  // Stage 1: centre difference d = B - A.
  // ---------------------------------------------------------------------------
  logic                v1;
  logic signed [W:0]   dx1, dy1;
  vel_t                vel1;
  logic [W-2:0]        contact1, ma1, mb1;
  logic                scored1;
  logic [EW-1:0]       e1_1;

  // ---------------------------------------------------------------------------
  // Stage 2: range check, magnitudes, squares and the mass products.
  // A difference that reaches half the word range can never overlap.
  // ---------------------------------------------------------------------------
  logic              inr_c;
  logic [W-2:0]      adx_c, ady_c;
  logic              v2, inr2, dxn2, dyn2;
  logic [W-2:0]      adx2, ady2;
  logic [2*W-3:0]    sqx2, sqy2, csq2;
  logic [KNW-1:0]    numa2, numb2;
  logic [W-1:0]      msum2;
  vel_t              vel2;
  logic [EW-1:0]     e1_2;

  always_comb begin
    logic signed [W:0] ndx;
    logic signed [W:0] ndy;
    logic              x_ok;
    logic              y_ok;
    ndx   = -dx1;
    ndy   = -dy1;
    x_ok  = (dx1[W] == dx1[W-1]) && !(dx1[W-1] && (dx1[W-2:0] == '0));
    y_ok  = (dy1[W] == dy1[W-1]) && !(dy1[W-1] && (dy1[W-2:0] == '0));
    inr_c = !scored1 && x_ok && y_ok;
    adx_c = dx1[W] ? ndx[W-2:0] : dx1[W-2:0];
    ady_c = dy1[W] ? ndy[W-2:0] : dy1[W-2:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared distance and the exact overlap test.
  // ---------------------------------------------------------------------------
  logic              v3;
  logic [2*W-2:0]    s_c;
  logic [2*W-2:0]    s3;
  sq_side_t          sq_in;

  assign s_c = (2*W-1)'(sqx2) + (2*W-1)'(sqy2);

  // ---------------------------------------------------------------------------
  // Square root of the squared distance, then the four divisions in parallel:
  // cos = dx / |d|, sin = dy / |d|, kA = e1*mB / (mA+mB), kB = e1*mA / (mA+mB).
  // ---------------------------------------------------------------------------
  logic           sq_v;
  logic [W-1:0]   sq_root;
  sq_side_t       sq_out;
  dv_side_t       dv_in, dv_out;

  bcr_isqrt #(
    .N      (W),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v3),
    .rad      ({1'b0, s3}),
    .side_in  (sq_in),
    .vout     (sq_v),
    .root     (sq_root),
    .side_out (sq_out)
  );

  assign dv_in = '{msum_zero: (sq_out.msum == '0), e1: sq_out.e1, vel: sq_out.vel};

  logic          cs_v, sn_v, ka_v, kb_v;
  logic [EW-1:0] q_cs, q_sn, q_ka, q_kb;
  logic          dxn_d, dyn_d, cand_d;

  bcr_div #(
    .NUM_W  (W - 1 + F),
    .DEN_W  (W),
    .Q_W    (EW),
    .SIDE_W ($bits(dv_side_t))
  ) u_div_cos (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (sq_v),
    .num      ({sq_out.adx, {F{1'b0}}}),
    .den      (sq_root),
    .side_in  (dv_in),
    .vout     (cs_v),
    .quo      (q_cs),
    .side_out (dv_out)
  );

  bcr_div #(
    .NUM_W  (W - 1 + F),
    .DEN_W  (W),
    .Q_W    (EW),
    .SIDE_W (1)
  ) u_div_sin (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (sq_v),
    .num      ({sq_out.ady, {F{1'b0}}}),
    .den      (sq_root),
    .side_in  (sq_out.dxn),
    .vout     (sn_v),
    .quo      (q_sn),
    .side_out (dxn_d)
  );

  bcr_div #(
    .NUM_W  (KNW),
    .DEN_W  (W),
    .Q_W    (EW),
    .SIDE_W (1)
  ) u_div_ka (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (sq_v),
    .num      (sq_out.numa),
    .den      (sq_out.msum),
    .side_in  (sq_out.dyn),
    .vout     (ka_v),
    .quo      (q_ka),
    .side_out (dyn_d)
  );

  bcr_div #(
    .NUM_W  (KNW),
    .DEN_W  (W),
    .Q_W    (EW),
    .SIDE_W (1)
  ) u_div_kb (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (sq_v),
    .num      (sq_out.numb),
    .den      (sq_out.msum),
    .side_in  (sq_out.cand),
    .vout     (kb_v),
    .quo      (q_kb),
    .side_out (cand_d)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: signed cos/sin and the mass ratios. With both masses zero each
  // ratio falls back to e1 / 2.
  // ---------------------------------------------------------------------------
  logic                 v4, cand4;
  logic signed [EW-1:0] cs4, sn4;
  logic [EW-1:0]        ka4, kb4;
  vel_t                 vel4;

  // ---------------------------------------------------------------------------
  // Stage 5: rotate both velocities into the normal frame (products).
  // ---------------------------------------------------------------------------
  logic                 v5, cand5;
  logic signed [PW-1:0] pa_xc5, pa_ys5, pa_yc5, pa_xs5;
  logic signed [PW-1:0] pb_xc5, pb_ys5, pb_yc5, pb_xs5;
  logic signed [EW-1:0] cs5, sn5;
  logic [EW-1:0]        ka5, kb5;
  vel_t                 vel5;

  // ---------------------------------------------------------------------------
  // Stage 6: normal and tangent components, floored.
  // ---------------------------------------------------------------------------
  logic                 v6, cand6;
  logic signed [NW-1:0] na6, ta6, nb6, tb6;
  logic signed [EW-1:0] cs6, sn6;
  logic [EW-1:0]        ka6, kb6;
  vel_t                 vel6;
  logic signed [PW:0]   na_sum, ta_sum, nb_sum, tb_sum;

  assign na_sum = (PW+1)'(pa_xc5) + (PW+1)'(pa_ys5);
  assign ta_sum = (PW+1)'(pa_yc5) - (PW+1)'(pa_xs5);
  assign nb_sum = (PW+1)'(pb_xc5) + (PW+1)'(pb_ys5);
  assign tb_sum = (PW+1)'(pb_yc5) - (PW+1)'(pb_xs5);

  // ---------------------------------------------------------------------------
  // Stage 7: approach test and the normal velocity differences.
  // ---------------------------------------------------------------------------
  logic                 v7, hit7;
  logic signed [NW:0]   dba7, dab7;
  logic signed [NW-1:0] na7, ta7, nb7, tb7;
  logic signed [EW-1:0] cs7, sn7;
  logic [EW-1:0]        ka7, kb7;
  vel_t                 vel7;

  // ---------------------------------------------------------------------------
  // Stage 8: impulse products kA*(nB-nA) and kB*(nA-nB).
  // ---------------------------------------------------------------------------
  logic                 v8, hit8;
  logic signed [KW-1:0] pka8, pkb8;
  logic signed [NW-1:0] na8, ta8, nb8, tb8;
  logic signed [EW-1:0] cs8, sn8;
  vel_t                 vel8;
  logic signed [EW:0]   ka_s, kb_s;

  assign ka_s = {1'b0, ka7};
  assign kb_s = {1'b0, kb7};

  // ---------------------------------------------------------------------------
  // Stage 9: new normal components.
  // ---------------------------------------------------------------------------
  logic                 v9, hit9;
  logic signed [N2-1:0] na9, nb9;
  logic signed [NW-1:0] ta9, tb9;
  logic signed [EW-1:0] cs9, sn9;
  vel_t                 vel9;

  // ---------------------------------------------------------------------------
  // Stage 10: rotate back into the world frame (products).
  // ---------------------------------------------------------------------------
  logic                 v10, hit10;
  logic signed [BW-1:0] ba_nc10, ba_ts10, ba_ns10, ba_tc10;
  logic signed [BW-1:0] bb_nc10, bb_ts10, bb_ns10, bb_tc10;
  vel_t                 vel10;

  // ---------------------------------------------------------------------------
  // Output stage: floor, saturate and pick the rotated or the original velocity.
  // ---------------------------------------------------------------------------
  logic signed [RW-1:0] rax, ray, rbx, rby;
  logic signed [W-1:0]  sax, say, sbx, sby;

  always_comb begin
    logic signed [BW:0] dax;
    logic signed [BW:0] day;
    logic signed [BW:0] dbx;
    logic signed [BW:0] dby;
    dax = (BW+1)'(ba_nc10) - (BW+1)'(ba_ts10);
    day = (BW+1)'(ba_ns10) + (BW+1)'(ba_tc10);
    dbx = (BW+1)'(bb_nc10) - (BW+1)'(bb_ts10);
    dby = (BW+1)'(bb_ns10) + (BW+1)'(bb_tc10);
    rax = RW'(dax >>> F);
    ray = RW'(day >>> F);
    rbx = RW'(dbx >>> F);
    rby = RW'(dby >>> F);
    sax = (rax > SAT_HI) ? W'(SAT_HI) : ((rax < SAT_LO) ? W'(SAT_LO) : rax[W-1:0]);
    say = (ray > SAT_HI) ? W'(SAT_HI) : ((ray < SAT_LO) ? W'(SAT_LO) : ray[W-1:0]);
    sbx = (rbx > SAT_HI) ? W'(SAT_HI) : ((rbx < SAT_LO) ? W'(SAT_LO) : rbx[W-1:0]);
    sby = (rby > SAT_HI) ? W'(SAT_HI) : ((rby < SAT_LO) ? W'(SAT_LO) : rby[W-1:0]);
  end

  // Valid bits of the hand-written stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= cs_v & sn_v & ka_v & kb_v;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      v8        <= v7;
      v9        <= v8;
      v10       <= v9;
      out_valid <= v10;
    end
  end

  // Payload of the hand-written stages.
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1
      dx1      <= (W+1)'(b_pos_x) - (W+1)'(a_pos_x);
      dy1      <= (W+1)'(b_pos_y) - (W+1)'(a_pos_y);
      vel1     <= vel_in;
      contact1 <= contact_distance;
      ma1      <= a_mass;
      mb1      <= b_mass;
      scored1  <= either_scored;
      e1_1     <= e1_in;
      // Stage 2
      inr2  <= inr_c;
      dxn2  <= dx1[W];
      dyn2  <= dy1[W];
      adx2  <= adx_c;
      ady2  <= ady_c;
      sqx2  <= adx_c * adx_c;
      sqy2  <= ady_c * ady_c;
      csq2  <= contact1 * contact1;
      numa2 <= e1_1 * mb1;
      numb2 <= e1_1 * ma1;
      msum2 <= W'(ma1) + W'(mb1);
      vel2  <= vel1;
      e1_2  <= e1_1;
      // Stage 3
      s3    <= s_c;
      sq_in <= '{cand: inr2 && (s_c != '0) && (s_c < (2*W-1)'(csq2)),
                 dxn: dxn2, dyn: dyn2, adx: adx2, ady: ady2, vel: vel2,
                 numa: numa2, numb: numb2, msum: msum2, e1: e1_2};
      // Stage 4
      cand4 <= cand_d;
      cs4   <= dxn_d ? -$signed(q_cs) : $signed(q_cs);
      sn4   <= dyn_d ? -$signed(q_sn) : $signed(q_sn);
      ka4   <= dv_out.msum_zero ? (dv_out.e1 >> 1) : q_ka;
      kb4   <= dv_out.msum_zero ? (dv_out.e1 >> 1) : q_kb;
      vel4  <= dv_out.vel;
      // Stage 5
      cand5  <= cand4;
      pa_xc5 <= vel4.vax * cs4;
      pa_ys5 <= vel4.vay * sn4;
      pa_yc5 <= vel4.vay * cs4;
      pa_xs5 <= vel4.vax * sn4;
      pb_xc5 <= vel4.vbx * cs4;
      pb_ys5 <= vel4.vby * sn4;
      pb_yc5 <= vel4.vby * cs4;
      pb_xs5 <= vel4.vbx * sn4;
      cs5    <= cs4;
      sn5    <= sn4;
      ka5    <= ka4;
      kb5    <= kb4;
      vel5   <= vel4;
      // Stage 6
      cand6 <= cand5;
      na6   <= NW'(na_sum >>> F);
      ta6   <= NW'(ta_sum >>> F);
      nb6   <= NW'(nb_sum >>> F);
      tb6   <= NW'(tb_sum >>> F);
      cs6   <= cs5;
      sn6   <= sn5;
      ka6   <= ka5;
      kb6   <= kb5;
      vel6  <= vel5;
      // Stage 7: the discs must be closing along the normal.
      hit7 <= cand6 && (na6 > nb6);
      dba7 <= (NW+1)'(nb6) - (NW+1)'(na6);
      dab7 <= (NW+1)'(na6) - (NW+1)'(nb6);
      na7  <= na6;
      ta7  <= ta6;
      nb7  <= nb6;
      tb7  <= tb6;
      cs7  <= cs6;
      sn7  <= sn6;
      ka7  <= ka6;
      kb7  <= kb6;
      vel7 <= vel6;
      // Stage 8
      hit8 <= hit7;
      pka8 <= ka_s * dba7;
      pkb8 <= kb_s * dab7;
      na8  <= na7;
      ta8  <= ta7;
      nb8  <= nb7;
      tb8  <= tb7;
      cs8  <= cs7;
      sn8  <= sn7;
      vel8 <= vel7;
      // Stage 9
      hit9 <= hit8;
      na9  <= N2'(na8) + N2'(pka8 >>> F);
      nb9  <= N2'(nb8) + N2'(pkb8 >>> F);
      ta9  <= ta8;
      tb9  <= tb8;
      cs9  <= cs8;
      sn9  <= sn8;
      vel9 <= vel8;
      // Stage 10
      hit10   <= hit9;
      ba_nc10 <= na9 * cs9;
      ba_ts10 <= ta9 * sn9;
      ba_ns10 <= na9 * sn9;
      ba_tc10 <= ta9 * cs9;
      bb_nc10 <= nb9 * cs9;
      bb_ts10 <= tb9 * sn9;
      bb_ns10 <= nb9 * sn9;
      bb_tc10 <= tb9 * cs9;
      vel10   <= vel9;
      // Output word
      hit         <= hit10;
      new_a_vel_x <= hit10 ? sax : vel10.vax;
      new_a_vel_y <= hit10 ? say : vel10.vay;
      new_b_vel_x <= hit10 ? sbx : vel10.vbx;
      new_b_vel_y <= hit10 ? sby : vel10.vby;
    end
  end

endmodule

@@ design/bcr_isqrt.sv @@
// Pipelined integer square root, one root bit resolved per stage.
`timescale 1ns / 1ps
module bcr_isqrt #(
  parameter int N      = bcr_pkg::WORD_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [2*N-1:0]    rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vout,
  output logic [N-1:0]      root,
  output logic [SIDE_W-1:0] side_out
);
  import bcr_pkg::*;

  logic [N+1:0]      rem_q     [N];
  logic [N-1:0]      root_q    [N];
  logic [2*N-1:0]    rad_q     [N];
  logic [SIDE_W-1:0] side_q    [N];
  logic [N+1:0]      rem_next  [N];
  logic [N-1:0]      root_next [N];
  logic [2*N-1:0]    rad_next  [N];
  logic [SIDE_W-1:0] side_next [N];
  logic [N-1:0]      vld_q;

  // Each stage brings down the next two radicand bits and tries 4q+1.
  always_comb begin
    logic [N+1:0]      rem_p;
    logic [N-1:0]      root_p;
    logic [2*N-1:0]    rad_p;
    logic [SIDE_W-1:0] side_p;
    logic [N+1:0]      rem_sh;
    logic [N+1:0]      trial;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = rad;
        side_p = side_in;
      end else begin
        rem_p  = rem_q[i-1];
        root_p = root_q[i-1];
        rad_p  = rad_q[i-1];
        side_p = side_q[i-1];
      end
      rem_sh = {rem_p[N-1:0], rad_p[2*N-1 -: 2]};
      trial  = {root_p, 2'b01};
      if (rem_sh >= trial) begin
        rem_next[i]  = rem_sh - trial;
        root_next[i] = {root_p[N-2:0], 1'b1};
      end else begin
        rem_next[i]  = rem_sh;
        root_next[i] = {root_p[N-2:0], 1'b0};
      end
      rad_next[i]  = rad_p << 2;
      side_next[i] = side_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N-2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem_q[i]  <= rem_next[i];
        root_q[i] <= root_next[i];
        rad_q[i]  <= rad_next[i];
        side_q[i] <= side_next[i];
      end
    end
  end

  assign vout     = vld_q[N-1];
  assign root     = root_q[N-1];
  assign side_out = side_q[N-1];

endmodule

@@ design/bcr_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bcr_div #(
  parameter int NUM_W  = bcr_pkg::WORD_WIDTH_DEF + bcr_pkg::FRAC_BITS_DEF,
  parameter int DEN_W  = bcr_pkg::WORD_WIDTH_DEF,
  parameter int Q_W    = bcr_pkg::FRAC_BITS_DEF + 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vout,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);
  import bcr_pkg::*;

  localparam int XW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [XW-1:0]     rem_q     [Q_W];
  logic [DEN_W-1:0]  den_q     [Q_W];
  logic [Q_W-1:0]    quo_q     [Q_W];
  logic [SIDE_W-1:0] side_q    [Q_W];
  logic [XW-1:0]     rem_next  [Q_W];
  logic [DEN_W-1:0]  den_next  [Q_W];
  logic [Q_W-1:0]    quo_next  [Q_W];
  logic [SIDE_W-1:0] side_next [Q_W];
  logic [Q_W-1:0]    vld_q;

  // The quotient must fit in Q_W bits; the caller guarantees that.
  always_comb begin
    logic [XW-1:0]     rem_p;
    logic [DEN_W-1:0]  den_p;
    logic [Q_W-1:0]    quo_p;
    logic [SIDE_W-1:0] side_p;
    logic [XW-1:0]     trial;
    for (int i = 0; i < Q_W; i++) begin
      if (i == 0) begin
        rem_p  = XW'(num);
        den_p  = den;
        quo_p  = '0;
        side_p = side_in;
      end else begin
        rem_p  = rem_q[i-1];
        den_p  = den_q[i-1];
        quo_p  = quo_q[i-1];
        side_p = side_q[i-1];
      end
      trial = XW'({den_p, {Q_W{1'b0}}} >> (i + 1));
      if (rem_p >= trial) begin
        rem_next[i] = rem_p - trial;
        quo_next[i] = quo_p | (Q_W'(1) << (Q_W - 1 - i));
      end else begin
        rem_next[i] = rem_p;
        quo_next[i] = quo_p;
      end
      den_next[i]  = den_p;
      side_next[i] = side_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Q_W-2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_W; i++) begin
        rem_q[i]  <= rem_next[i];
        den_q[i]  <= den_next[i];
        quo_q[i]  <= quo_next[i];
        side_q[i] <= side_next[i];
      end
    end
  end

  assign vout     = vld_q[Q_W-1];
  assign quo      = quo_q[Q_W-1];
  assign side_out = side_q[Q_W-1];

endmodule

@@ tb/ball_collision_response_2d_tb.sv @@
// Self-checking testbench for the two-disc collision response pipeline.
`timescale 1ns / 1ps
module ball_collision_response_2d_tb;
  import bcr_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam int LATENCY = W + F + 13;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS = 2000;

  // One disc pair as it is presented to the block.
  typedef struct packed {
    logic signed [W-1:0] ax, ay, bx, by;
    logic signed [W-1:0] vax, vay, vbx, vby;
    logic [W-2:0] contact;
    logic [W-2:0] ma, mb;
    logic scored;
  } pair_t;

  // One response word.
  typedef struct packed {
    logic signed [W-1:0] vax, vay, vbx, vby;
    logic hit;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  pair_t drv_pair = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  response_t got;

  // Restitution as the predictor sees it; it follows every register write.
  logic [REST_W-1:0] restitution_shadow;

  pair_t pending_pairs[$];
  response_t expected_responses[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int hits_seen = 0;
  int idle_cycles = 0;

  // The clock toggles with a period of 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ball_collision_response_2d DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_pos_x(drv_pair.ax), .a_pos_y(drv_pair.ay),
    .b_pos_x(drv_pair.bx), .b_pos_y(drv_pair.by),
    .a_vel_x(drv_pair.vax), .a_vel_y(drv_pair.vay),
    .b_vel_x(drv_pair.vbx), .b_vel_y(drv_pair.vby),
    .contact_distance(drv_pair.contact), .a_mass(drv_pair.ma), .b_mass(drv_pair.mb),
    .either_scored(drv_pair.scored),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_a_vel_x(got.vax), .new_a_vel_y(got.vay),
    .new_b_vel_x(got.vbx), .new_b_vel_y(got.vby), .hit(got.hit)
  );

  // Arithmetic right shift that rounds toward minus infinity.
  function automatic longint floor_div_frac(input longint x);
    return x >>> F;
  endfunction

  function automatic logic signed [W-1:0] clamp_word(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[W-1:0];
  endfunction

  // Integer square root, rounded down, on a 64-bit sum of squares.
  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Works out the velocities after one step for a pair of discs.
  function automatic response_t collide(input pair_t p, input logic [REST_W-1:0] rest);
    response_t r;
    longint dx, dy, lim, one, m, cs, sn, na, ta, nb, tb, ka, kb, na2, nb2;
    longint unsigned s, contact_sq, e1, msum;
    r.vax = p.vax;
    r.vay = p.vay;
    r.vbx = p.vbx;
    r.vby = p.vby;
    r.hit = 1'b0;
    one = longint'(1) <<< F;
    lim = longint'(1) <<< (W - 1);
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    // A scored disc or a centre gap reaching half the word range never collides.
    if (!p.scored && dx < lim && -dx < lim && dy < lim && -dy < lim) begin
      s = longint'(dx * dx) + longint'(dy * dy);
      contact_sq = longint'(p.contact) * longint'(p.contact);
      if (s != 0 && s < contact_sq) begin
        m = root_floor(s);
        cs = (dx * one) / m;
        sn = (dy * one) / m;
        na = floor_div_frac(longint'(p.vax) * cs + longint'(p.vay) * sn);
        ta = floor_div_frac(longint'(p.vay) * cs - longint'(p.vax) * sn);
        nb = floor_div_frac(longint'(p.vbx) * cs + longint'(p.vby) * sn);
        tb = floor_div_frac(longint'(p.vby) * cs - longint'(p.vbx) * sn);
        // Only an approaching pair exchanges momentum.
        if (na > nb) begin
          e1 = one + ((rest > one) ? one : rest);
          msum = longint'(p.ma) + longint'(p.mb);
          if (msum == 0) begin
            ka = e1 >> 1;
            kb = ka;
          end else begin
            ka = (e1 * p.mb) / msum;
            kb = (e1 * p.ma) / msum;
          end
          na2 = na + floor_div_frac(ka * (nb - na));
          nb2 = nb + floor_div_frac(kb * (na - nb));
          r.vax = clamp_word(floor_div_frac(na2 * cs - ta * sn));
          r.vay = clamp_word(floor_div_frac(na2 * sn + ta * cs));
          r.vbx = clamp_word(floor_div_frac(nb2 * cs - tb * sn));
          r.vby = clamp_word(floor_div_frac(nb2 * sn + tb * cs));
          r.hit = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Short or occasionally long idle gap, with many words sent back to back.
  function automatic int idle_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: presents queued pairs, holding each one steady while it is stalled.
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // The current word (if any) was accepted at this edge; pick the next one.
      if (in_valid) words_sent <= words_sent + 1;
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        drv_pair <= pending_pairs[0];
        expected_responses.push_back(collide(pending_pairs[0], restitution_shadow));
        void'(pending_pairs.pop_front());
        in_valid <= 1'b1;
        drv_gap <= idle_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted response word and draws a new stall pattern.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: response word with nothing expected: %p", $time, got);
          errors <= errors + 1;
        end else begin
          if (got !== expected_responses[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time,
                     expected_responses[0], got);
            errors <= errors + 1;
          end
          if (got.hit) hits_seen <= hits_seen + 1;
          void'(expected_responses.pop_front());
        end
        words_checked <= words_checked + 1;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= idle_gap();
        out_stall <= 1'b0;
      end
      // Watchdog on cycles without any accepted word on either side.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d words outstanding", $time,
               expected_responses.size());
      $display("ball_collision_response_2d_tb: FAIL");
      $finish;
    end
  end

  task automatic write_restitution(input logic [REST_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_RESTITUTION, 2'b00};
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    restitution_shadow = value;
  endtask

  // Waits until every queued word is through, then lets the pipeline drain.
  task automatic wait_idle();
    while (pending_pairs.size() > 0 || in_valid || expected_responses.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_word();
    return $urandom();
  endfunction

  // A random pair; mostly overlapping and approaching so the response path is busy.
  function automatic pair_t make_pair();
    pair_t p;
    int k;
    int unsigned span;
    p.ax = $signed($urandom()) >>> $urandom_range(0, 12);
    p.ay = $signed($urandom()) >>> $urandom_range(0, 12);
    p.vax = $signed($urandom()) >>> $urandom_range(0, 14);
    p.vay = $signed($urandom()) >>> $urandom_range(0, 14);
    p.vbx = $signed($urandom()) >>> $urandom_range(0, 14);
    p.vby = $signed($urandom()) >>> $urandom_range(0, 14);
    p.ma = (W-1)'($urandom() >> $urandom_range(1, 16));
    p.mb = (W-1)'($urandom() >> $urandom_range(1, 16));
    p.scored = ($urandom_range(0, 15) == 0);
    k = $urandom_range(0, 9);
    if (k < 8) begin
      span = 32'd1 << $urandom_range(4, 24);
      p.bx = p.ax + $signed(32'($urandom_range(0, span))) - $signed(span / 2);
      p.by = p.ay + $signed(32'($urandom_range(0, span))) - $signed(span / 2);
      p.contact = (W-1)'($urandom_range(span / 4, span));
      // Point velocities toward each other often enough to collide.
      if ($urandom_range(0, 1)) begin
        p.vax = (p.bx - p.ax) >>> $urandom_range(0, 4);
        p.vbx = -((p.bx - p.ax) >>> $urandom_range(0, 4));
      end
    end else begin
      p.bx = rand_word();
      p.by = rand_word();
      p.contact = (W-1)'($urandom());
      p.vax = rand_word();
      p.vay = rand_word();
      p.ma = (W-1)'($urandom());
      p.mb = (W-1)'($urandom());
    end
    return p;
  endfunction

  function automatic pair_t head_on(input int sep, input int contact,
                                    input int va, input int vb);
    pair_t p;
    p = '0;
    p.bx = sep;
    p.vax = va;
    p.vbx = vb;
    p.contact = (W-1)'(contact);
    p.ma = 31'h10000;
    p.mb = 31'h10000;
    return p;
  endfunction

  initial begin
    pair_t p;
    logic [REST_W-1:0] rest_settings[5];
    restitution_shadow = REST_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words with the reset restitution (fully elastic).
    pending_pairs.push_back(head_on(32'h18000, 32'h20000, 32'h10000, -32'h10000));
    p = head_on(32'h18000, 32'h20000, 32'h10000, -32'h10000);
    p.scored = 1'b1;
    pending_pairs.push_back(p);
    pending_pairs.push_back(head_on(0, 32'h20000, 32'h10000, 0));
    pending_pairs.push_back(head_on(32'h20000, 32'h20000, 32'h10000, 0));
    pending_pairs.push_back(head_on(32'h18000, 32'h20000, -32'h10000, 32'h10000));
    p = head_on(32'h8000, 32'h10000, 32'h7fffffff, 32'h80000000);
    pending_pairs.push_back(p);
    p = head_on(32'h18000, 32'h20000, 32'h10000, 0);
    p.ma = 0;
    p.mb = 0;
    pending_pairs.push_back(p);
    p.ma = 31'h7fffffff;
    p.mb = 1;
    pending_pairs.push_back(p);
    p = '0;
    p.ax = 32'h80000000;
    p.bx = 32'h7fffffff;
    p.contact = 31'h7fffffff;
    p.vax = 32'h10000;
    pending_pairs.push_back(p);
    p = '0;
    p.ay = 32'h80000000;
    p.by = 32'h00000000;
    p.contact = 31'h7fffffff;
    pending_pairs.push_back(p);
    p = head_on(32'h1000, 32'h2000, 32'h7fffffff, 32'h80000000);
    p.by = 32'h800;
    p.vay = 32'h7fffffff;
    p.vby = 32'h80000000;
    p.ma = 31'h7fffffff;
    p.mb = 31'h7fffffff;
    pending_pairs.push_back(p);
    p = '1;
    p.scored = 1'b0;
    pending_pairs.push_back(p);
    wait_idle();

    // Random phases across restitution settings, extremes included.
    rest_settings = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768, 17'd0};
    foreach (rest_settings[i]) begin
      if (i == 4) rest_settings[i] = REST_W'($urandom_range(1, 65535));
      write_restitution(rest_settings[i]);
      repeat (RANDOM_WORDS / 5) pending_pairs.push_back(make_pair());
      wait_idle();
    end

    $display("Sent %0d disc pairs and checked %0d responses, %0d of them collisions,",
             words_sent, words_checked, hits_seen);
    $display("across five restitution settings from inelastic to above one.");
    if (errors == 0) begin
      $display("ball_collision_response_2d_tb: PASS");
    end else begin
      $display("ball_collision_response_2d_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bcr_pkg.sv
design/bcr_isqrt.sv
design/bcr_div.sv
design/ball_collision_response_2d.sv
tb/ball_collision_response_2d_tb.sv
